>>> rtl/core/soften_neighbourhood_average_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbourhood average block
// Shared property forms used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef SOFTEN_NEIGHBOURHOOD_AVERAGE_TOP_ASSERT_SVH
`define SOFTEN_NEIGHBOURHOOD_AVERAGE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNAVG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SNAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/snavg_pkg.sv
// ----------------------------------------------------------------------------
// snavg_pkg
// Types, widths and codes shared by the neighbourhood average block.
// ----------------------------------------------------------------------------
package snavg_pkg;

    // Default canvas limits for the frame store.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Field widths.
    localparam int COORD_W    = 16;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 3 * CHAN_W;
    localparam int SIZE_REG_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COUNT_W    = 4;
    localparam int SUM_W      = 12;
    localparam int NUM_CHAN   = 3;

    // Reset values and limits.
    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [COUNT_W-1:0]    COUNT_FULL = 4'd9;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_WIDTH  = 2'd0,
        REG_CANVAS_HEIGHT = 2'd1,
        REG_WRAP_MODE     = 2'd2
    } cfg_reg_t;

    // Item commands.
    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Neighbour offset along one axis: minus one, zero, plus one.
    typedef enum logic [1:0] {
        TAP_LO  = 2'd0,
        TAP_MID = 2'd1,
        TAP_HI  = 2'd2
    } tap_t;

    // Configuration register file.
    typedef struct packed {
        logic [SIZE_REG_W-1:0] canvas_width;
        logic [SIZE_REG_W-1:0] canvas_height;
        logic                  wrap_mode;
    } cfg_regs_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_READ,
        S_SETTLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } seq_state_t;

    // Step to the next neighbour offset, wrapping back to the low one.
    function automatic tap_t next_tap(input tap_t t);
        tap_t n;
        unique case (t)
            TAP_LO:  n = TAP_MID;
            TAP_MID: n = TAP_HI;
            default: n = TAP_LO;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/snavg_ifs.sv
// ----------------------------------------------------------------------------
// snavg interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------

// Item channel: pixel writes and neighbourhood queries.
interface snavg_item_if
    import snavg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [CHAN_W-1:0]         in_red;
    logic [CHAN_W-1:0]         in_green;
    logic [CHAN_W-1:0]         in_blue;

    modport source (output valid, cmd, pos_x, pos_y, in_red, in_green, in_blue,
                    input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, in_red, in_green, in_blue,
                    output ready);
endinterface

// Result channel: one transfer per query.
interface snavg_result_if
    import snavg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  avg_red;
    logic [CHAN_W-1:0]  avg_green;
    logic [CHAN_W-1:0]  avg_blue;
    logic [COUNT_W-1:0] used_count;
    logic               status;

    modport source (output valid, avg_red, avg_green, avg_blue, used_count, status,
                    input ready);
    modport sink   (input valid, avg_red, avg_green, avg_blue, used_count, status,
                    output ready);
endinterface

// Configuration write channel.
interface snavg_cfg_if
    import snavg_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/snavg_mem.sv
// ----------------------------------------------------------------------------
// snavg_mem
// Single-port frame store holding one RGB pixel per entry, registered read.
// ----------------------------------------------------------------------------
module snavg_mem
    import snavg_pkg::*;
#(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
)
(
    input  logic               clk,
    input  logic               we,
    input  logic               re,
    input  logic [AW-1:0]      addr,
    input  logic [PIXEL_W-1:0] wdata,
    output logic [PIXEL_W-1:0] rdata
);

    logic [PIXEL_W-1:0] mem_array [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
    end

    // Read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/snavg_mod.sv
// ----------------------------------------------------------------------------
// snavg_mod
// Two-lane bit-serial modulo unit that maps signed coordinates into the canvas.
// ----------------------------------------------------------------------------
module snavg_mod
    import snavg_pkg::*;
#(
    parameter int NW = 9
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] value   [2],
    input  logic [NW-1:0]             divisor [2],
    output logic                      done,
    output logic [NW-1:0]             rem     [2]
);

    localparam int STEP_W = $clog2(COORD_W);

    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COORD_W-1:0] mag_reg [2];
    logic [NW-1:0]      rem_reg [2];
    logic [NW-1:0]      dvs_reg [2];
    logic               neg_reg [2];
    logic [COORD_W-1:0] mag     [2];
    logic [NW:0]        trial   [2];
    logic [NW:0]        diff    [2];

    // Magnitude of the input and one restoring step per lane.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag[i]   = value[i][COORD_W-1] ? (~value[i] + COORD_W'(1)) : value[i];
            trial[i] = {rem_reg[i], mag_reg[i][COORD_W-1]};
            diff[i]  = trial[i] - {1'b0, dvs_reg[i]};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(COORD_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Partial remainders, one dividend bit per cycle.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (start)
            begin
                mag_reg[i] <= mag[i];
                rem_reg[i] <= '0;
                dvs_reg[i] <= divisor[i];
                neg_reg[i] <= value[i][COORD_W-1];
            end
            else if (busy_reg)
            begin
                mag_reg[i] <= {mag_reg[i][COORD_W-2:0], 1'b0};
                if (trial[i] >= {1'b0, dvs_reg[i]})
                begin
                    rem_reg[i] <= diff[i][NW-1:0];
                end
                else
                begin
                    rem_reg[i] <= trial[i][NW-1:0];
                end
            end
        end
    end

    // A negative input with a nonzero remainder folds back from the divisor.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem[i] = (neg_reg[i] && (rem_reg[i] != '0)) ? (dvs_reg[i] - rem_reg[i])
                                                        : rem_reg[i];
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/core/snavg_div.sv
// ----------------------------------------------------------------------------
// snavg_div
// Three-lane restoring divider that turns channel sums into rounded averages.
// ----------------------------------------------------------------------------
module snavg_div
    import snavg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend [NUM_CHAN],
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [CHAN_W-1:0]  quotient [NUM_CHAN]
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [SUM_W-1:0]   quo_reg [NUM_CHAN];
    logic [COUNT_W-1:0] rem_reg [NUM_CHAN];
    logic [COUNT_W:0]   trial   [NUM_CHAN];
    logic [COUNT_W:0]   diff    [NUM_CHAN];

    // One trial subtraction per lane.
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            trial[i] = {rem_reg[i], quo_reg[i][SUM_W-1]};
            diff[i]  = trial[i] - {1'b0, dvs_reg};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Quotient bits shift in as dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
        end
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (start)
            begin
                quo_reg[i] <= dividend[i];
                rem_reg[i] <= '0;
            end
            else if (busy_reg)
            begin
                if (trial[i] >= {1'b0, dvs_reg})
                begin
                    rem_reg[i] <= diff[i][COUNT_W-1:0];
                    quo_reg[i] <= {quo_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= trial[i][COUNT_W-1:0];
                    quo_reg[i] <= {quo_reg[i][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Averages never exceed one channel, so the low bits hold the result.
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            quotient[i] = quo_reg[i][CHAN_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/core/snavg_seq.sv
// ----------------------------------------------------------------------------
// snavg_seq
// Sequencer: wraps or clips coordinates, then writes a pixel to the frame store
// or reads the 3x3 neighbourhood, sums, divides, holds the result for transfer.
// ----------------------------------------------------------------------------
`include "soften_neighbourhood_average_top_assert.svh"

module snavg_seq
    import snavg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_regs_t             cfg_regs,
    snavg_item_if.sink            item,
    snavg_result_if.source        result
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SWX   = $clog2(MAX_WIDTH + 1);
    localparam int SWY   = $clog2(MAX_HEIGHT + 1);
    localparam int NW    = (SWX > SWY) ? SWX : SWY;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    seq_state_t          state_reg, state_next;
    tap_t                tx_reg, ty_reg;
    cmd_t                cmd_reg;
    logic                flag_reg;
    logic                rd_pend_reg;
    logic [XW-1:0]       xc_reg;
    logic [YW-1:0]       yc_reg;
    logic [PIXEL_W-1:0]  rgb_reg;
    logic [SUM_W-1:0]    sum_reg [NUM_CHAN];
    logic [COUNT_W-1:0]  cnt_reg;
    logic                out_valid_reg;
    logic [CHAN_W-1:0]   avg_red_reg, avg_green_reg, avg_blue_reg;
    logic [COUNT_W-1:0]  used_count_reg;
    logic                status_reg;

    logic                wrap;
    logic [SWX-1:0]      eff_w, wm1;
    logic [SWY-1:0]      eff_h, hm1;
    logic                in_range;
    logic                accept;
    logic                item_ready;
    logic                mod_start, mod_done;
    logic                mem_we, mem_re;
    logic                div_start, div_done;
    logic                out_load;
    logic [XW-1:0]       tap_x, ax;
    logic [YW-1:0]       tap_y, ay;
    logic                tap_x_ok, tap_y_ok, tap_ok;
    logic [AW-1:0]       mem_addr;
    logic [PIXEL_W-1:0]  mem_rdata;
    logic signed [COORD_W-1:0] mod_value   [2];
    logic [NW-1:0]       mod_divisor [2];
    logic [NW-1:0]       mod_rem     [2];
    logic [SUM_W-1:0]    div_dividend [NUM_CHAN];
    logic [CHAN_W-1:0]   div_quotient [NUM_CHAN];

    // Effective canvas size: zero acts as one, oversize saturates.
    always_comb
    begin
        priority if (cfg_regs.canvas_width == '0)
            eff_w = SWX'(1);
        else if (32'(cfg_regs.canvas_width) > MAX_WIDTH)
            eff_w = SWX'(MAX_WIDTH);
        else
            eff_w = SWX'(cfg_regs.canvas_width);

        priority if (cfg_regs.canvas_height == '0)
            eff_h = SWY'(1);
        else if (32'(cfg_regs.canvas_height) > MAX_HEIGHT)
            eff_h = SWY'(MAX_HEIGHT);
        else
            eff_h = SWY'(cfg_regs.canvas_height);
    end

    assign wrap = cfg_regs.wrap_mode;
    assign wm1  = eff_w - SWX'(1);
    assign hm1  = eff_h - SWY'(1);

    // Position of the incoming item against the clip window.
    assign in_range = !item.pos_x[COORD_W-1] && (item.pos_x[COORD_W-2:0] < 15'(eff_w)) &&
                      !item.pos_y[COORD_W-1] && (item.pos_y[COORD_W-2:0] < 15'(eff_h));
    assign accept   = item.valid && item_ready;

    // Column of the current neighbour.
    always_comb
    begin
        tap_x    = xc_reg;
        tap_x_ok = 1'b1;
        unique case (tx_reg)
            TAP_LO:
            begin
                if (xc_reg == '0)
                begin
                    tap_x    = wm1[XW-1:0];
                    tap_x_ok = wrap;
                end
                else
                begin
                    tap_x = xc_reg - XW'(1);
                end
            end
            TAP_MID:
            begin
                tap_x = xc_reg;
            end
            TAP_HI:
            begin
                if (SWX'(xc_reg) == wm1)
                begin
                    tap_x    = '0;
                    tap_x_ok = wrap;
                end
                else
                begin
                    tap_x = xc_reg + XW'(1);
                end
            end
            default:
            begin
                tap_x_ok = 1'b0;
            end
        endcase
    end

    // Row of the current neighbour.
    always_comb
    begin
        tap_y    = yc_reg;
        tap_y_ok = 1'b1;
        unique case (ty_reg)
            TAP_LO:
            begin
                if (yc_reg == '0)
                begin
                    tap_y    = hm1[YW-1:0];
                    tap_y_ok = wrap;
                end
                else
                begin
                    tap_y = yc_reg - YW'(1);
                end
            end
            TAP_MID:
            begin
                tap_y = yc_reg;
            end
            TAP_HI:
            begin
                if (SWY'(yc_reg) == hm1)
                begin
                    tap_y    = '0;
                    tap_y_ok = wrap;
                end
                else
                begin
                    tap_y = yc_reg + YW'(1);
                end
            end
            default:
            begin
                tap_y_ok = 1'b0;
            end
        endcase
    end

    assign tap_ok = tap_x_ok && tap_y_ok;

    // Frame store address: row stride is the maximum width.
    assign ax       = (state_reg == S_WRITE) ? xc_reg : tap_x;
    assign ay       = (state_reg == S_WRITE) ? yc_reg : tap_y;
    assign mem_addr = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    priority if (wrap)
                        state_next = S_MOD;
                    else if (!in_range)
                        state_next = (item.cmd == CMD_QUERY) ? S_EMIT : S_IDLE;
                    else
                        state_next = (item.cmd == CMD_QUERY) ? S_READ : S_WRITE;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = (cmd_reg == CMD_QUERY) ? S_READ : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                if ((tx_reg == TAP_HI) && (ty_reg == TAP_HI))
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        item_ready = 1'b0;
        mod_start  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                mod_start  = item.valid && wrap;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            S_READ:
            begin
                mem_re = tap_ok;
            end
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            S_EMIT:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tx_reg        <= TAP_LO;
            ty_reg        <= TAP_LO;
            rd_pend_reg   <= 1'b0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            if (accept)
            begin
                tx_reg   <= TAP_LO;
                ty_reg   <= TAP_LO;
                flag_reg <= (item.cmd == CMD_QUERY) && !wrap && !in_range;
            end
            else if (state_reg == S_READ)
            begin
                tx_reg <= next_tap(tx_reg);
                if (tx_reg == TAP_HI)
                begin
                    ty_reg <= next_tap(ty_reg);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload, centre coordinates and channel sums.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_t'(item.cmd);
            rgb_reg <= {item.in_red, item.in_green, item.in_blue};
            xc_reg  <= item.pos_x[XW-1:0];
            yc_reg  <= item.pos_y[YW-1:0];
            cnt_reg <= '0;
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (mod_done)
            begin
                xc_reg <= mod_rem[0][XW-1:0];
                yc_reg <= mod_rem[1][YW-1:0];
            end
            if (rd_pend_reg)
            begin
                cnt_reg    <= cnt_reg + COUNT_W'(1);
                sum_reg[0] <= sum_reg[0] + SUM_W'(mem_rdata[3*CHAN_W-1:2*CHAN_W]);
                sum_reg[1] <= sum_reg[1] + SUM_W'(mem_rdata[2*CHAN_W-1:CHAN_W]);
                sum_reg[2] <= sum_reg[2] + SUM_W'(mem_rdata[CHAN_W-1:0]);
            end
        end
    end

    // Result register, loaded from the divider or with the clip flag.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (flag_reg)
            begin
                avg_red_reg    <= '0;
                avg_green_reg  <= '0;
                avg_blue_reg   <= '0;
                used_count_reg <= '0;
                status_reg     <= 1'b1;
            end
            else
            begin
                avg_red_reg    <= div_quotient[0];
                avg_green_reg  <= div_quotient[1];
                avg_blue_reg   <= div_quotient[2];
                used_count_reg <= cnt_reg;
                status_reg     <= 1'b0;
            end
        end
    end

    assign item.ready        = item_ready;
    assign result.valid      = out_valid_reg;
    assign result.avg_red    = avg_red_reg;
    assign result.avg_green  = avg_green_reg;
    assign result.avg_blue   = avg_blue_reg;
    assign result.used_count = used_count_reg;
    assign result.status     = status_reg;

    // Coordinate wrapping.
    assign mod_value[0]   = item.pos_x;
    assign mod_value[1]   = item.pos_y;
    assign mod_divisor[0] = NW'(eff_w);
    assign mod_divisor[1] = NW'(eff_h);

    snavg_mod #(
        .NW (NW)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .divisor (mod_divisor),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // Frame store.
    snavg_mem #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (rgb_reg),
        .rdata (mem_rdata)
    );

    // Rounded averages: half the count is added before the division.
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            div_dividend[i] = sum_reg[i] + SUM_W'(cnt_reg >> 1);
        end
    end

    snavg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A flagged result carries no colour and no count.
    `SNAVG_ASSERT_SAME(a_flag_zero, clk, rst_n, result.valid && result.status,
        (result.used_count == '0) && (result.avg_red == '0) && (result.avg_green == '0) &&
        (result.avg_blue == '0), "flagged result carries data")
    // A normal result averages at least one and at most nine pixels.
    `SNAVG_ASSERT_SAME(a_count_range, clk, rst_n, result.valid && !result.status,
        (result.used_count != '0) && (result.used_count <= COUNT_FULL),
        "used count out of range")
    // A query always leaves the idle state.
    `SNAVG_ASSERT_NEXT(a_query_busy, clk, rst_n, accept && (item.cmd == CMD_QUERY),
        !item.ready, "still ready after a query transfer")
    // Read data only arrives while the neighbourhood is being gathered.
    `SNAVG_ASSERT_SAME(a_read_window, clk, rst_n, rd_pend_reg,
        (state_reg == S_READ) || (state_reg == S_SETTLE), "stray frame store read")
    // The wrap unit finishes only while the sequencer waits for it.
    `SNAVG_ASSERT_SAME(a_mod_window, clk, rst_n, mod_done, state_reg == S_MOD,
        "wrap result outside its wait state")

endmodule

>>> rtl/core/soften_neighbourhood_average_top.sv
// ----------------------------------------------------------------------------
// soften_neighbourhood_average_top
// 3x3 box average over an RGB canvas held in a frame store.
// ----------------------------------------------------------------------------
// A query reads up to nine neighbours from the frame store over its one port,
// then runs the 12-step divider. In wrap mode, queries and writes first pass
// through the 16-step coordinate modulo unit. One item is worked at a time.
// Reset clears the control state and sets the canvas to 256 x 256 in clip mode;
// the frame store is not cleared and holds nothing valid until written.
module soften_neighbourhood_average_top
    import snavg_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic           clk,
    input  logic           rst_n,
    snavg_cfg_if.sink      cfg,
    snavg_item_if.sink     item,
    snavg_result_if.source result
);

    cfg_regs_t cfg_regs_reg, cfg_regs_next;

    // Configuration writes; unknown indexes are dropped.
    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_CANVAS_WIDTH:  cfg_regs_next.canvas_width  = cfg.data;
                REG_CANVAS_HEIGHT: cfg_regs_next.canvas_height = cfg.data;
                REG_WRAP_MODE:     cfg_regs_next.wrap_mode     = cfg.data[0];
                default:           cfg_regs_next = cfg_regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg <= '{canvas_width:  SIZE_RESET,
                              canvas_height: SIZE_RESET,
                              wrap_mode:     1'b0};
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Sequencer with frame store, wrap unit and divider.
    snavg_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_regs_reg),
        .item     (item),
        .result   (result)
    );

endmodule

>>> tb/tb_soften_neighbourhood_average_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_soften_neighbourhood_average_top
// Checks the 3x3 box average block against a predictor of the canvas. Pixel
// writes and queries go in over the item channel, and register writes are made
// only while the block is quiet. Every query result is checked field by field
// against the predicted average, count and status. A short table of edge cases
// comes first. Random traffic follows under several sender and receiver
// idling patterns and canvas settings.
// ----------------------------------------------------------------------------
module tb_soften_neighbourhood_average_top;

    import snavg_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int QUIET_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_GAP         = 40;
    localparam int SEGMENT_ITEMS   = 66;
    localparam int REPORT_LIMIT    = 50;

    // Register index past the end of the register file; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [CHAN_W-1:0]         in_red;
        logic [CHAN_W-1:0]         in_green;
        logic [CHAN_W-1:0]         in_blue;
    } pixel_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  avg_red;
        logic [CHAN_W-1:0]  avg_green;
        logic [CHAN_W-1:0]  avg_blue;
        logic [COUNT_W-1:0] used_count;
        logic               status;
    } blur_result_t;

    // One row of the directed table: a register write or an item.
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        pixel_item_t           px;
        bit                    known;
        blur_result_t          known_res;
    } stim_row_t;

    typedef int tap_list_t [9];

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    snavg_cfg_if    cfg_bus ();
    snavg_item_if   item_bus ();
    snavg_result_if result_bus ();

    soften_neighbourhood_average_top u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .item   (item_bus),
        .result (result_bus)
    );

    // Shadow of the block: canvas contents, which pixels hold data, registers.
    logic [PIXEL_W-1:0]    canvas_copy [0:MAX_W*MAX_H-1];
    bit                    pixel_written [0:MAX_W*MAX_H-1];
    logic [SIZE_REG_W-1:0] width_reg  = SIZE_RESET;
    logic [SIZE_REG_W-1:0] height_reg = SIZE_RESET;
    logic                  wrap_reg   = 1'b0;

    blur_result_t pending_blurs [$];
    stim_row_t    rows [$];
    int           counted_items = 0;
    int           fail_count    = 0;
    int           idle_pct      = 0;
    int           stall_pct     = 0;
    int           quiet_cycles  = 0;

    // Clock: 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Size register as the block uses it: zero acts as one, large values saturate.
    function automatic int size_eff(input logic [SIZE_REG_W-1:0] r, input int maxv);
        if (r == 0)
            return 1;
        if (r > maxv)
            return maxv;
        return int'(r);
    endfunction

    function automatic int wrap_index(input int c, input int n);
        int m;
        m = c % n;
        if (m < 0)
            m += n;
        return m;
    endfunction

    function automatic int rand_coord();
        return int'($signed(16'($urandom)));
    endfunction

    function automatic logic [SIZE_REG_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 9'd256;
            2:       return 9'h1FF;
            3:       return 9'($urandom_range(511, 257));
            4:       return 9'd1;
            default: return 9'($urandom_range(8, 2));
        endcase
    endfunction

    // Frame store address of a write, or 0 when a clipped write falls off the canvas.
    function automatic bit locate_write(input int x, input int y, output int addr);
        int w;
        int h;
        w = size_eff(width_reg, MAX_W);
        h = size_eff(height_reg, MAX_H);
        addr = 0;
        if (wrap_reg)
        begin
            x = wrap_index(x, w);
            y = wrap_index(y, h);
        end
        else if (x < 0 || x >= w || y < 0 || y >= h)
        begin
            return 1'b0;
        end
        addr = y * MAX_W + x;
        return 1'b1;
    endfunction

    // Addresses of the neighbourhood pixels that a query reads. Zero means the
    // centre lies off a clipped canvas.
    function automatic int collect_taps(input int cx, input int cy, output tap_list_t addrs);
        int w;
        int h;
        int n;
        int tx;
        int ty;
        w = size_eff(width_reg, MAX_W);
        h = size_eff(height_reg, MAX_H);
        n = 0;
        addrs = '{default: 0};
        if (!wrap_reg && (cx < 0 || cx >= w || cy < 0 || cy >= h))
            return 0;
        for (int dy = -1; dy <= 1; dy++)
        begin
            for (int dx = -1; dx <= 1; dx++)
            begin
                tx = cx + dx;
                ty = cy + dy;
                if (wrap_reg)
                begin
                    tx = wrap_index(tx, w);
                    ty = wrap_index(ty, h);
                end
                else if (tx < 0 || tx >= w || ty < 0 || ty >= h)
                begin
                    continue;
                end
                addrs[n] = ty * MAX_W + tx;
                n++;
            end
        end
        return n;
    endfunction

    // Rounded per-channel average over the neighbourhood.
    function automatic blur_result_t predict_blur(input int cx, input int cy);
        tap_list_t    addrs;
        int           n;
        int           sr;
        int           sg;
        int           sb;
        blur_result_t res;
        res = '0;
        sr = 0;
        sg = 0;
        sb = 0;
        n = collect_taps(cx, cy, addrs);
        if (n == 0)
        begin
            res.status = 1'b1;
            return res;
        end
        for (int i = 0; i < n; i++)
        begin
            sr += canvas_copy[addrs[i]][23:16];
            sg += canvas_copy[addrs[i]][15:8];
            sb += canvas_copy[addrs[i]][7:0];
        end
        res.avg_red    = 8'((sr + n / 2) / n);
        res.avg_green  = 8'((sg + n / 2) / n);
        res.avg_blue   = 8'((sb + n / 2) / n);
        res.used_count = 4'(n);
        return res;
    endfunction

    function automatic pixel_item_t make_item(input cmd_t c, input int x, input int y,
                                              input logic [PIXEL_W-1:0] rgb);
        pixel_item_t it;
        it.cmd      = c;
        it.pos_x    = 16'(x);
        it.pos_y    = 16'(y);
        it.in_red   = rgb[23:16];
        it.in_green = rgb[15:8];
        it.in_blue  = rgb[7:0];
        return it;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t px_row(input cmd_t c, input int x, input int y,
                                         input logic [PIXEL_W-1:0] rgb);
        stim_row_t r;
        r = '{default: '0};
        r.px = make_item(c, x, y, rgb);
        return r;
    endfunction

    // Query whose result is plain: all channels at one level.
    function automatic stim_row_t known_row(input int x, input int y, input logic [7:0] level,
                                            input logic [3:0] n, input logic flag);
        stim_row_t r;
        r = px_row(CMD_QUERY, x, y, 24'h5A5A5A);
        r.known     = 1'b1;
        r.known_res = '{level, level, level, n, flag};
        return r;
    endfunction

    // Update the shadow for an accepted item and queue the expected result.
    task automatic track_item(input pixel_item_t it, input bit known,
                              input blur_result_t known_res);
        int addr;
        if (it.cmd == CMD_WRITE)
        begin
            if (locate_write(int'(it.pos_x), int'(it.pos_y), addr))
            begin
                canvas_copy[addr]   = {it.in_red, it.in_green, it.in_blue};
                pixel_written[addr] = 1'b1;
                counted_items++;
            end
        end
        else
        begin
            pending_blurs.push_back(known ? known_res
                                          : predict_blur(int'(it.pos_x), int'(it.pos_y)));
            counted_items++;
        end
    endtask

    // Present one item, with a random idle gap first, and wait for its transfer.
    task automatic send_pixel_item(input pixel_item_t it, input bit known,
                                   input blur_result_t known_res);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.cmd      <= it.cmd;
        item_bus.pos_x    <= it.pos_x;
        item_bus.pos_y    <= it.pos_y;
        item_bus.in_red   <= it.in_red;
        item_bus.in_green <= it.in_green;
        item_bus.in_blue  <= it.in_blue;
        do
            @(posedge clk);
        while (!(item_bus.valid && item_bus.ready));
        track_item(it, known, known_res);
    endtask

    // Write any unwritten neighbour first, so the query never reads stale memory.
    task automatic send_filled_query(input int x, input int y);
        tap_list_t addrs;
        int        n;
        n = collect_taps(x, y, addrs);
        for (int i = 0; i < n; i++)
        begin
            if (!pixel_written[addrs[i]])
                send_pixel_item(make_item(CMD_WRITE, addrs[i] % MAX_W, addrs[i] / MAX_W,
                                          24'($urandom)), 1'b0, '0);
        end
        send_pixel_item(make_item(CMD_QUERY, x, y, 24'($urandom)), 1'b0, '0);
    endtask

    // Register write; valid stays high so writes can go back to back.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        case (idx)
            REG_CANVAS_WIDTH:  width_reg  = val;
            REG_CANVAS_HEIGHT: height_reg = val;
            REG_WRAP_MODE:     wrap_reg   = val[0];
            default:           ;
        endcase
    endtask

    // Stop sending, wait for every result, then give a trailing write time to land.
    task automatic wait_until_quiet();
        item_bus.valid <= 1'b0;
        cfg_bus.valid  <= 1'b0;
        while (pending_blurs.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic configure_canvas();
        write_register(REG_CANVAS_WIDTH, pick_size());
        write_register(REG_CANVAS_HEIGHT, pick_size());
        write_register(REG_WRAP_MODE, 9'($urandom));
        if ($urandom_range(3) == 0)
            write_register(REG_UNUSED, 9'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // Random traffic: mostly in-canvas writes and queries near the canvas,
    // with some queries and writes at arbitrary coordinates.
    task automatic run_random(input int goal);
        int w;
        int h;
        int pick;
        while (counted_items < goal)
        begin
            w = size_eff(width_reg, MAX_W);
            h = size_eff(height_reg, MAX_H);
            pick = $urandom_range(99);
            if (pick < 35)
                send_pixel_item(make_item(CMD_WRITE, $urandom_range(w - 1),
                                          $urandom_range(h - 1), 24'($urandom)), 1'b0, '0);
            else if (pick < 75)
                send_filled_query(int'($urandom_range(w + 1)) - 1,
                                  int'($urandom_range(h + 1)) - 1);
            else if (pick < 88)
                send_filled_query(rand_coord(), rand_coord());
            else
                send_pixel_item(make_item(CMD_WRITE, rand_coord(), rand_coord(),
                                          24'($urandom)), 1'b0, '0);
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_blur(input blur_result_t got);
        blur_result_t want;
        if (pending_blurs.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: result with no query waiting: expected none, got %h",
                         $time, got);
        end
        else
        begin
            want = pending_blurs.pop_front();
            report_field("avg_red", want.avg_red, got.avg_red);
            report_field("avg_green", want.avg_green, got.avg_green);
            report_field("avg_blue", want.avg_blue, got.avg_blue);
            report_field("used_count", want.used_count, got.used_count);
            report_field("status", want.status, got.status);
        end
    endtask

    // Result receiver: held off during reset, then random back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checking.
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            check_blur(blur_result_t'({result_bus.avg_red, result_bus.avg_green,
                                       result_bus.avg_blue, result_bus.used_count,
                                       result_bus.status}));
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** soften_neighbourhood_average_top: FAILED **");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        bit after_item;
        after_item = 1'b0;

        item_bus.valid    <= 1'b0;
        item_bus.cmd      <= CMD_WRITE;
        item_bus.pos_x    <= '0;
        item_bus.pos_y    <= '0;
        item_bus.in_red   <= '0;
        item_bus.in_green <= '0;
        item_bus.in_blue  <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_CANVAS_WIDTH;
        cfg_bus.data      <= '0;

        // Directed table: a small clipped canvas filled with white, then edges,
        // off-canvas centres, ignored writes, wrapping, size zero, size saturation
        // and the unused register index.
        rows.push_back(reg_row(REG_CANVAS_WIDTH, 9'd3));
        rows.push_back(reg_row(REG_CANVAS_HEIGHT, 9'd3));
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                rows.push_back(px_row(CMD_WRITE, x, y, 24'hFFFFFF));
        rows.push_back(known_row(1, 1, 8'd255, 4'd9, 1'b0));
        rows.push_back(known_row(0, 0, 8'd255, 4'd4, 1'b0));
        rows.push_back(known_row(2, 1, 8'd255, 4'd6, 1'b0));
        rows.push_back(known_row(-1, 0, 8'd0, 4'd0, 1'b1));
        rows.push_back(known_row(32767, -32768, 8'd0, 4'd0, 1'b1));
        rows.push_back(known_row(3, 2, 8'd0, 4'd0, 1'b1));
        rows.push_back(px_row(CMD_WRITE, 1, 1, 24'h000000));
        rows.push_back(px_row(CMD_WRITE, -1, 5, 24'h123456));
        rows.push_back(px_row(CMD_QUERY, 1, 1, 24'h0));
        rows.push_back(reg_row(REG_WRAP_MODE, 9'd1));
        rows.push_back(px_row(CMD_QUERY, -32768, 32767, 24'hFFFFFF));
        rows.push_back(px_row(CMD_WRITE, -32768, -32768, 24'h12C807));
        rows.push_back(px_row(CMD_QUERY, 0, 0, 24'h0));
        rows.push_back(reg_row(REG_CANVAS_WIDTH, 9'd0));
        rows.push_back(px_row(CMD_QUERY, 7, -1, 24'h0));
        rows.push_back(reg_row(REG_UNUSED, 9'h1FF));
        rows.push_back(reg_row(REG_WRAP_MODE, 9'h0FE));
        rows.push_back(px_row(CMD_QUERY, 0, 1, 24'h0));
        rows.push_back(reg_row(REG_CANVAS_WIDTH, 9'h1FF));
        rows.push_back(reg_row(REG_CANVAS_HEIGHT, 9'd300));
        rows.push_back(px_row(CMD_QUERY, 0, 0, 24'h0));
        rows.push_back(known_row(256, 0, 8'd0, 4'd0, 1'b1));
        rows.push_back(known_row(0, 256, 8'd0, 4'd0, 1'b1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with no idling on either side.
        foreach (rows[i])
        begin
            if (rows[i].is_reg)
            begin
                if (after_item)
                    wait_until_quiet();
                write_register(rows[i].reg_idx, rows[i].reg_val);
                after_item = 1'b0;
            end
            else
            begin
                cfg_bus.valid <= 1'b0;
                send_pixel_item(rows[i].px, rows[i].known, rows[i].known_res);
                after_item = 1'b1;
            end
        end

        // Random part: four idling patterns, two canvas settings each.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    idle_pct  = 25;
                    stall_pct = 25;
                end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                wait_until_quiet();
                configure_canvas();
                run_random(counted_items + SEGMENT_ITEMS);
            end
        end

        wait_until_quiet();
        if (fail_count == 0)
            $display("** soften_neighbourhood_average_top: PASSED **");
        else
            $display("** soften_neighbourhood_average_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/snavg_pkg.sv
rtl/core/snavg_ifs.sv
rtl/core/snavg_mem.sv
rtl/core/snavg_mod.sv
rtl/core/snavg_div.sv
rtl/core/snavg_seq.sv
rtl/core/soften_neighbourhood_average_top.sv
tb/tb_soften_neighbourhood_average_top.sv
